>>> hdl/spf_pkg.sv
`default_nettype none
package spf_pkg;

  localparam int WORD_W  = 16;
  localparam int MAX_RES = 6;
  localparam int CNT_W   = 3;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_SI_RD,
    ST_SI_CHK,
    ST_SJ_RD,
    ST_SJ_CHK,
    ST_IDLE,
    ST_RD,
    ST_LOOK,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quo;
    logic [WORD_W-1:0] rem;
  } div_res_t;

endpackage
`default_nettype wire

>>> hdl/spf_ram.sv
`default_nettype none
module spf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hdl/spf_div.sv
`default_nettype none
module spf_div
  import spf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] dividend,
  input  wire logic [WORD_W-1:0] divisor,
  output div_res_t               res
);

  localparam int CW = $clog2(WORD_W + 1);

  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] quo;
  logic [WORD_W-1:0] dvs;
  logic [CW-1:0]     cnt;
  logic              busy;
  logic              done;
  logic [WORD_W:0]   sh;
  logic              ge;
  logic [WORD_W:0]   diff;

  // one quotient bit per cycle, restoring
  always_comb begin
    sh   = {rem, quo[WORD_W-1]};
    diff = sh - {1'b0, dvs};
    ge   = (sh >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(WORD_W);
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= ge ? diff[WORD_W-1:0] : sh[WORD_W-1:0];
        quo <= {quo[WORD_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done = done;
  assign res.quo  = quo;
  assign res.rem  = rem;

endmodule
`default_nettype wire

>>> hdl/spf_sieve_prime_factorizer_unit.sv
`default_nettype none
// After reset: a clearing pass over min(TABLE_SIZE,65536) entries, then the
// sieve (a read state and a check state per table read-modify-write); in_ready
// stays low until both end. Per query: a read and a lookup state, one serial
// trial division per power of each prime, plus one, and an emit per result;
// values 0, 1 or out of range go straight to emit. One query at a time.
module spf_sieve_prime_factorizer_unit
  import spf_pkg::*;
#(
  parameter int TABLE_SIZE = 65536
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [WORD_W-1:0] value,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [WORD_W-1:0]      factor,
  output logic                   is_last,
  output logic                   empty_res
);

  // queries are 16-bit, so entries past 2^16 are never read
  localparam int DEPTH = (TABLE_SIZE > 65536) ? 65536 : TABLE_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = (AW + 1) / 2 + 1;

  state_t            state, state_next;
  logic [IW-1:0]     i;
  logic [AW:0]       j;
  logic [2*IW-1:0]   sq;
  logic [AW:0]       j_step;
  logic [WORD_W-1:0] n;
  logic [WORD_W-1:0] p;
  logic [WORD_W-1:0] p_look;
  logic              pend_last;
  logic              pend_empty;
  logic [CNT_W-1:0]  count;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [WORD_W-1:0] wdata;
  logic [AW-1:0]     raddr;
  logic [WORD_W-1:0] rdata;
  logic              div_start;
  logic [WORD_W-1:0] div_dvd;
  logic [WORD_W-1:0] div_dvs;
  div_res_t          div_res;
  logic              accept;
  logic              bad_value;
  logic              out_free;
  logic              div_last;

  spf_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  spf_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dvd),
    .divisor (div_dvs),
    .res     (div_res)
  );

  always_comb begin
    sq        = (2*IW)'(i) * (2*IW)'(i);
    j_step    = j + (AW+1)'(i);
    accept    = in_valid && in_ready;
    bad_value = (value < WORD_W'(2)) || (32'(value) >= TABLE_SIZE);
    out_free  = !out_valid || out_ready;
    div_last  = (n == WORD_W'(1)) || (count == CNT_W'(MAX_RES - 1));
    // zero past the sieve bound means n is prime
    p_look    = (rdata == '0) ? n : rdata;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLR:    if (j[AW-1:0] == AW'(DEPTH - 1)) state_next = ST_SI_RD;
      ST_SI_RD:  state_next = (32'(sq) >= DEPTH) ? ST_IDLE : ST_SI_CHK;
      ST_SI_CHK: state_next = (rdata == '0) ? ST_SJ_RD : ST_SI_RD;
      ST_SJ_RD:  state_next = ST_SJ_CHK;
      ST_SJ_CHK: state_next = (32'(j_step) >= DEPTH) ? ST_SI_RD : ST_SJ_RD;
      ST_IDLE:   if (accept) state_next = bad_value ? ST_EMIT : ST_RD;
      ST_RD:     state_next = ST_LOOK;
      ST_LOOK:   state_next = ST_DIV;
      ST_DIV:    if (div_res.done && div_res.rem != '0) state_next = ST_EMIT;
      ST_EMIT:   if (out_free) state_next = pend_last ? ST_IDLE : ST_RD;
      default:   state_next = ST_CLR;
    endcase
  end

  // outputs to table and divider, and in_ready
  always_comb begin
    we        = 1'b0;
    waddr     = j[AW-1:0];
    wdata     = '0;
    raddr     = n[AW-1:0];
    in_ready  = 1'b0;
    div_start = 1'b0;
    div_dvd   = n;
    div_dvs   = p;
    unique case (state)
      ST_CLR:    we = 1'b1;
      ST_SI_RD:  raddr = AW'(i);
      ST_SI_CHK: begin
        we    = (rdata == '0);
        waddr = AW'(i);
        wdata = WORD_W'(i);
      end
      ST_SJ_RD:  raddr = j[AW-1:0];
      ST_SJ_CHK: begin
        we    = (rdata == '0);
        wdata = WORD_W'(i);
      end
      ST_IDLE:   in_ready = 1'b1;
      ST_LOOK:   begin
        div_start = 1'b1;
        div_dvs   = p_look;
      end
      ST_DIV:    begin
        div_start = div_res.done && (div_res.rem == '0);
        div_dvd   = div_res.quo;
      end
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      out_valid <= 1'b0;
      i         <= IW'(2);
      j         <= '0;
      count     <= '0;
    end else begin
      state <= state_next;
      if (state == ST_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLR:    j <= j + 1'b1;
        ST_SI_RD:  ;
        ST_SI_CHK: begin
          if (rdata == '0) begin
            j <= (AW+1)'(sq);
          end else begin
            i <= i + 1'b1;
          end
        end
        ST_SJ_RD:  ;
        ST_SJ_CHK: begin
          j <= j_step;
          if (32'(j_step) >= DEPTH) begin
            i <= i + 1'b1;
          end
        end
        ST_IDLE:   begin
          if (accept) begin
            n          <= value;
            count      <= '0;
            p          <= '0;
            pend_last  <= 1'b1;
            pend_empty <= bad_value;
          end
        end
        ST_RD:     ;
        ST_LOOK:   begin
          p          <= p_look;
          pend_empty <= 1'b0;
        end
        ST_DIV:    begin
          if (div_res.done) begin
            if (div_res.rem == '0) begin
              n <= div_res.quo;
            end else begin
              pend_last <= div_last;
            end
          end
        end
        ST_EMIT:   begin
          if (out_free) begin
            factor    <= p;
            is_last   <= pend_last;
            empty_res <= pend_empty;
            count     <= count + 1'b1;
          end
        end
        default:   ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sim/tb_spf_sieve_prime_factorizer_unit.sv
`default_nettype none
module tb_spf_sieve_prime_factorizer_unit;
  import spf_pkg::*;

  localparam int TBL = 65536;
  localparam longint CYCLE_LIMIT = 64'd6000000;

  typedef struct packed {
    logic [WORD_W-1:0] factor;
    logic              is_last;
    logic              empty_res;
  } fact_res_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [WORD_W-1:0] value;
  logic              out_valid;
  logic              out_ready;
  logic [WORD_W-1:0] factor;
  logic              is_last;
  logic              empty_res;

  logic [WORD_W-1:0] spf_tbl [TBL];
  fact_res_t         pending_factors[$];
  int                n_fail;
  int                n_queries;
  int                n_results;
  longint            cycles;
  bit                idle_en;

  spf_sieve_prime_factorizer_unit #(.TABLE_SIZE(TBL)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .factor(factor), .is_last(is_last), .empty_res(empty_res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout at %0t", $time);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic build_spf_table();
    int i;
    longint j;
    for (i = 0; i < TBL; i++) spf_tbl[i] = '0;
    for (i = 2; i < TBL; i++) begin
      if (spf_tbl[i] == 0) begin
        spf_tbl[i] = i[WORD_W-1:0];
        for (j = longint'(i) * i; j < TBL; j += i)
          if (spf_tbl[j] == 0) spf_tbl[j] = i[WORD_W-1:0];
      end
    end
  endtask

  task automatic queue_result(input fact_res_t r);
    pending_factors = {pending_factors, r};
  endtask

  task automatic predict_factors(input logic [WORD_W-1:0] v);
    int n;
    int p;
    int cnt;
    fact_res_t r;
    n = v;
    cnt = 0;
    if (n < 2 || n >= TBL) begin
      r = '{factor: '0, is_last: 1'b1, empty_res: 1'b1};
      queue_result(r);
      return;
    end
    while (n > 1 && cnt < MAX_RES) begin
      p = spf_tbl[n];
      if (p < 2) break;
      while (n % p == 0) n = n / p;
      r = '{factor: p[WORD_W-1:0], is_last: 1'b0, empty_res: 1'b0};
      queue_result(r);
      cnt++;
    end
    if (cnt == 0) begin
      r = '{factor: '0, is_last: 1'b1, empty_res: 1'b1};
      queue_result(r);
    end else begin
      pending_factors[$].is_last = 1'b1;
    end
  endtask

  // valid stays up between transfers unless an idle gap is taken
  task automatic send_value(input logic [WORD_W-1:0] v);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    predict_factors(v);
    n_queries++;
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  // result checker; while idle_en is set, the sink stalls in random bursts
  initial begin
    fact_res_t exp_r;
    int stall;
    out_ready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        n_results++;
        if (pending_factors.size() == 0) begin
          $display("%0t: unexpected result factor=%0d last=%0b empty=%0b",
                   $time, factor, is_last, empty_res);
          n_fail++;
        end else begin
          exp_r = pending_factors.pop_front();
          if (factor !== exp_r.factor) begin
            $display("%0t: factor exp %0d got %0d", $time, exp_r.factor, factor);
            n_fail++;
          end
          if (is_last !== exp_r.is_last) begin
            $display("%0t: is_last exp %0b got %0b", $time, exp_r.is_last, is_last);
            n_fail++;
          end
          if (empty_res !== exp_r.empty_res) begin
            $display("%0t: empty_res exp %0b got %0b", $time, exp_r.empty_res,
                     empty_res);
            n_fail++;
          end
        end
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(0, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic test_directed();
    logic [WORD_W-1:0] vals [] = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd65535,
      16'd65521, 16'd65534, 16'd32768, 16'd30030, 16'd51758, 16'd9699,
      16'd510, 16'd255, 16'd49, 16'd65025, 16'd2310, 16'd43691, 16'd1024};
    foreach (vals[k]) send_value(vals[k]);
  endtask

  task automatic test_random_values();
    int k;
    logic [WORD_W-1:0] v;
    for (k = 0; k < 400; k++) begin
      case ($urandom_range(0, 3))
        0: v = 16'($urandom_range(0, 65535));
        1: v = 16'($urandom_range(0, 255));
        2: v = 16'(30030 * $urandom_range(1, 2));
        default: v = ~16'($urandom_range(0, 255));
      endcase
      send_value(v);
    end
  endtask

  task automatic test_back_to_back();
    int k;
    idle_en = 1'b0;
    for (k = 0; k < 80; k++) send_value(16'($urandom_range(0, 65535)));
  endtask

  initial begin
    n_fail = 0;
    n_queries = 0;
    n_results = 0;
    idle_en = 1'b1;
    rst = 1'b1;
    in_valid = 1'b0;
    value = '0;
    build_spf_table();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_values();
    test_back_to_back();
    in_valid <= 1'b0;
    while (pending_factors.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("%0d queries sent, %0d factor results checked, %0d mismatches",
             n_queries, n_results, n_fail);
    if (n_fail == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
